// ===== src/uccs_pkg.sv =====
package uccs_pkg;

  localparam logic [7:0] BIT_TICKS_RESET   = 8'd12;
  localparam logic [7:0] START_TICKS_RESET = 8'd13;

  localparam logic       CFG_BIT_TICKS   = 1'b0;
  localparam logic       CFG_START_TICKS = 1'b1;

  typedef struct packed {
    logic       tx_level;
    logic [2:0] chip_enable_n;
    logic [1:0] channel_select;
    logic       led_on;
    logic       busy_res;
  } result_t;

endpackage

// ===== src/uart_command_channel_selector.sv =====
// Serial command decoder with echo. Each input transfer is one timer tick
// carrying the sampled receive level; each tick gives exactly one result
// transfer with the transmit level, the active-low chip enables, the channel
// select, the LED and the busy flag as they stand after that tick. A new tick
// is taken every cycle: the tick's state update is one pass of logic into the
// state registers, and the result sits in a single output register that is
// refilled in the same cycle it is taken, so the rate is one tick per clock
// whenever the output side is ready. bit_ticks (index 0) and start_ticks
// (index 1) set the bit and echoed start-bit lengths in ticks; write them only
// while the block is idle.
module uart_command_channel_selector (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       rx_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_level,
  output logic [2:0] chip_enable_n,
  output logic [1:0] channel_select,
  output logic       led_on,
  output logic       busy_res,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import uccs_pkg::*;

  result_t res_next;
  result_t res_out;
  logic    space;
  logic    step;

  assign in_ready = space;
  assign step     = in_valid && space;

  uccs_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .rx_level  (rx_level),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_next  (res_next)
  );

  uccs_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_next),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .space     (space),
    .res_out   (res_out)
  );

  assign tx_level       = res_out.tx_level;
  assign chip_enable_n  = res_out.chip_enable_n;
  assign channel_select = res_out.channel_select;
  assign led_on         = res_out.led_on;
  assign busy_res       = res_out.busy_res;

endmodule

// ===== src/uccs_core.sv =====
module uccs_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            rx_level,
  input  logic            cfg_write,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  output uccs_pkg::result_t res_next
);
  import uccs_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_RX_START = 3'd1;
  localparam logic [2:0] PH_RX_DATA  = 3'd2;
  localparam logic [2:0] PH_RX_STOP  = 3'd3;
  localparam logic [2:0] PH_TX_START = 3'd4;
  localparam logic [2:0] PH_TX_DATA  = 3'd5;
  localparam logic [2:0] PH_TX_STOP  = 3'd6;

  localparam logic [7:0] CMD_CHIP1_LO = 8'h30;
  localparam logic [7:0] CMD_CHIP2_LO = 8'h32;
  localparam logic [7:0] CMD_CHIP3_LO = 8'h36;

  localparam logic [2:0] EN_CHIP1 = 3'b110;
  localparam logic [2:0] EN_CHIP2 = 3'b101;
  localparam logic [2:0] EN_CHIP3 = 3'b011;

  logic [7:0] bit_ticks;
  logic [7:0] start_ticks;

  logic       previous_rx, previous_rx_next;
  logic [2:0] phase, phase_next;
  logic [7:0] tick_count, tick_count_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] received_byte, received_byte_next;
  logic [2:0] enables_reg, enables_reg_next;
  logic [1:0] channel_reg, channel_reg_next;
  logic       led_reg, led_reg_next;
  logic       tx_reg, tx_reg_next;

  logic [7:0] dur;
  logic [7:0] tick_inc;
  logic [3:0] bit_inc;
  logic [7:0] cmd_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks   <= BIT_TICKS_RESET;
      start_ticks <= START_TICKS_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_BIT_TICKS) begin
        bit_ticks <= cfg_data;
      end else begin
        start_ticks <= cfg_data;
      end
    end
  end

  always_comb begin
    dur      = (phase == PH_TX_START) ? start_ticks : bit_ticks;
    tick_inc = tick_count + 8'd1;
    bit_inc  = bit_index + 4'd1;
    cmd_off  = 8'd0;

    previous_rx_next   = rx_level;
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    received_byte_next = received_byte;
    enables_reg_next   = enables_reg;
    channel_reg_next   = channel_reg;
    led_reg_next       = led_reg;
    tx_reg_next        = tx_reg;

    if (phase == PH_IDLE) begin
      if (previous_rx && !rx_level) begin
        phase_next         = PH_RX_START;
        tick_count_next    = 8'd0;
        bit_index_next     = 4'd0;
        received_byte_next = 8'd0;
      end
    end else begin
      tick_count_next = tick_inc;
      if (tick_inc >= dur) begin
        tick_count_next = 8'd0;
        case (phase)
          PH_RX_START: begin
            phase_next     = PH_RX_DATA;
            bit_index_next = 4'd0;
          end
          PH_RX_DATA: begin
            received_byte_next = received_byte | (8'(rx_level) << bit_index[2:0]);
            bit_index_next     = bit_inc;
            if (bit_inc >= 4'd8) begin
              bit_index_next = 4'd0;
              phase_next     = PH_RX_STOP;
            end
          end
          PH_RX_STOP: begin
            phase_next  = PH_TX_START;
            tx_reg_next = 1'b0;
          end
          PH_TX_START: begin
            phase_next     = PH_TX_DATA;
            bit_index_next = 4'd0;
            tx_reg_next    = received_byte[0];
          end
          PH_TX_DATA: begin
            bit_index_next = bit_inc;
            if (bit_inc >= 4'd8) begin
              bit_index_next = 4'd0;
              phase_next     = PH_TX_STOP;
              tx_reg_next    = 1'b1;
            end else begin
              tx_reg_next = received_byte[bit_inc[2:0]];
            end
          end
          default: begin
            phase_next  = PH_IDLE;
            tx_reg_next = 1'b1;
            led_reg_next = 1'b1;
            case (received_byte) inside
              [8'h30:8'h31]: begin
                cmd_off          = received_byte - CMD_CHIP1_LO;
                enables_reg_next = EN_CHIP1;
                channel_reg_next = cmd_off[1:0];
              end
              [8'h32:8'h35]: begin
                cmd_off          = received_byte - CMD_CHIP2_LO;
                enables_reg_next = EN_CHIP2;
                channel_reg_next = cmd_off[1:0];
              end
              [8'h36:8'h39]: begin
                cmd_off          = received_byte - CMD_CHIP3_LO;
                enables_reg_next = EN_CHIP3;
                channel_reg_next = cmd_off[1:0];
              end
              default: begin
                led_reg_next = 1'b0;
              end
            endcase
          end
        endcase
      end
    end

    res_next.tx_level       = tx_reg_next;
    res_next.chip_enable_n  = enables_reg_next;
    res_next.channel_select = channel_reg_next;
    res_next.led_on         = led_reg_next;
    res_next.busy_res       = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_rx   <= 1'b1;
      phase         <= PH_IDLE;
      tick_count    <= 8'd0;
      bit_index     <= 4'd0;
      received_byte <= 8'd0;
      enables_reg   <= EN_CHIP1;
      channel_reg   <= 2'd0;
      led_reg       <= 1'b1;
      tx_reg        <= 1'b1;
    end else if (step) begin
      previous_rx   <= previous_rx_next;
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      received_byte <= received_byte_next;
      enables_reg   <= enables_reg_next;
      channel_reg   <= channel_reg_next;
      led_reg       <= led_reg_next;
      tx_reg        <= tx_reg_next;
    end
  end

endmodule

// ===== src/uccs_out.sv =====
module uccs_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  uccs_pkg::result_t res_in,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              space,
  output uccs_pkg::result_t res_out
);
  import uccs_pkg::*;

  // holds one result; refills in the cycle it is taken
  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import uccs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [2:0]  CHIP1_SEL_N  = 3'b110;
  localparam logic [2:0]  CHIP2_SEL_N  = 3'b101;
  localparam logic [2:0]  CHIP3_SEL_N  = 3'b011;

  typedef enum logic [2:0] {
    LINE_IDLE, RX_START, RX_DATA, RX_STOP, TX_START, TX_DATA, TX_STOP
  } line_phase_e;

  class selector_scoreboard;
    logic [7:0]  bit_len;
    logic [7:0]  start_len;
    logic        prev_rx;
    line_phase_e link_phase;
    logic [7:0]  tick_cnt;
    logic [3:0]  bit_idx;
    logic [7:0]  rx_byte;
    logic [2:0]  enables_n;
    logic [1:0]  channel;
    logic        led;
    logic        tx;
    result_t     expected_q[$];
    int unsigned errors;
    int unsigned ticks;
    int unsigned commands;
    int unsigned rejects;

    function new();
      bit_len    = BIT_TICKS_RESET;
      start_len  = START_TICKS_RESET;
      prev_rx    = 1'b1;
      link_phase = LINE_IDLE;
      tick_cnt   = '0;
      bit_idx    = '0;
      rx_byte    = '0;
      enables_n  = CHIP1_SEL_N;
      channel    = '0;
      led        = 1'b1;
      tx         = 1'b1;
      errors     = 0;
      ticks      = 0;
      commands   = 0;
      rejects    = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] val);
      if (idx == CFG_BIT_TICKS) begin
        bit_len = val;
      end else begin
        start_len = val;
      end
    endfunction

    function bit is_busy();
      return link_phase != LINE_IDLE;
    endfunction

    // true when the next tick ends the echoed stop bit
    function bit last_busy_tick();
      return link_phase == TX_STOP && int'(tick_cnt) + 1 >= int'(bit_len);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void decode_byte(logic [7:0] b);
      if (b >= "0" && b <= "1") begin
        enables_n = CHIP1_SEL_N;
        channel   = 2'(b - "0");
        led       = 1'b1;
        commands++;
      end else if (b >= "2" && b <= "5") begin
        enables_n = CHIP2_SEL_N;
        channel   = 2'(b - "2");
        led       = 1'b1;
        commands++;
      end else if (b >= "6" && b <= "9") begin
        enables_n = CHIP3_SEL_N;
        channel   = 2'(b - "6");
        led       = 1'b1;
        commands++;
      end else begin
        led = 1'b0;
        rejects++;
      end
    endfunction

    // one accepted tick: advance the line state and queue the outputs it gives
    function void note_tick(logic rx);
      logic [7:0] dur;
      result_t    r;
      ticks++;
      if (link_phase == LINE_IDLE) begin
        if (prev_rx && !rx) begin
          link_phase = RX_START;
          tick_cnt   = '0;
          bit_idx    = '0;
          rx_byte    = '0;
        end
      end else begin
        dur      = (link_phase == TX_START) ? start_len : bit_len;
        tick_cnt = tick_cnt + 8'd1;
        if (tick_cnt >= dur) begin
          tick_cnt = '0;
          case (link_phase)
            RX_START: begin
              link_phase = RX_DATA;
              bit_idx    = '0;
            end
            RX_DATA: begin
              rx_byte[bit_idx[2:0]] = rx_byte[bit_idx[2:0]] | rx;
              bit_idx++;
              if (bit_idx >= 4'd8) begin
                bit_idx    = '0;
                link_phase = RX_STOP;
              end
            end
            RX_STOP: begin
              link_phase = TX_START;
              tx         = 1'b0;
            end
            TX_START: begin
              link_phase = TX_DATA;
              bit_idx    = '0;
              tx         = rx_byte[0];
            end
            TX_DATA: begin
              bit_idx++;
              if (bit_idx >= 4'd8) begin
                bit_idx    = '0;
                link_phase = TX_STOP;
                tx         = 1'b1;
              end else begin
                tx = rx_byte[bit_idx[2:0]];
              end
            end
            default: begin
              link_phase = LINE_IDLE;
              tx         = 1'b1;
              decode_byte(rx_byte);
            end
          endcase
        end
      end
      prev_rx = rx;
      r.tx_level       = tx;
      r.chip_enable_n  = enables_n;
      r.channel_select = channel;
      r.led_on         = led;
      r.busy_res       = (link_phase != LINE_IDLE);
      expected_q.push_back(r);
    endfunction

    function void check(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.tx_level !== want.tx_level) begin
        $error("tx_level: expected %0d, actual %0d", want.tx_level, got.tx_level);
        errors++;
      end
      if (got.chip_enable_n !== want.chip_enable_n) begin
        $error("chip_enable_n: expected %0d, actual %0d",
               want.chip_enable_n, got.chip_enable_n);
        errors++;
      end
      if (got.channel_select !== want.channel_select) begin
        $error("channel_select: expected %0d, actual %0d",
               want.channel_select, got.channel_select);
        errors++;
      end
      if (got.led_on !== want.led_on) begin
        $error("led_on: expected %0d, actual %0d", want.led_on, got.led_on);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0d, actual %0d", want.busy_res, got.busy_res);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic       rx_level;
  logic       out_valid;
  logic       out_ready;
  logic       tx_level;
  logic [2:0] chip_enable_n;
  logic [1:0] channel_select;
  logic       led_on;
  logic       busy_res;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;

  selector_scoreboard sb;
  int unsigned        cycle_count = 0;
  int unsigned        src_idle_pct = 0;
  int unsigned        sink_stall_pct = 0;
  bit                 hold_out = 1'b0;

  uart_command_channel_selector DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_level       (rx_level),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .tx_level       (tx_level),
    .chip_enable_n  (chip_enable_n),
    .channel_select (channel_select),
    .led_on         (led_on),
    .busy_res       (busy_res),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[uart_command_channel_selector] ERROR");
    $finish;
  end

  // receiver side, with one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check({tx_level, chip_enable_n, channel_select, led_on, busy_res});
    end
  end

  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(lvl);
    @(negedge clk);
  endtask

  // one 8n1 frame; noisy puts random levels everywhere but the start edge and the sample ticks,
  // end_edge drops the line on the tick that ends the echo
  task automatic send_frame(input logic [7:0] b, input bit noisy, input bit end_edge);
    int bt;
    int t;
    int j;
    bit sample_tick;
    logic lvl;
    while (sb.is_busy()) send_tick(1'b1);
    repeat ($urandom_range(1, 4)) send_tick(1'b1);
    bt = (sb.bit_len == 0) ? 1 : int'(sb.bit_len);
    send_tick(1'b0);
    for (t = 1; t <= 10 * bt; t++) begin
      j = (t - 1) / bt;
      lvl = (j == 0) ? 1'b0 : (j <= 8) ? b[j - 1] : 1'b1;
      sample_tick = (t % bt == 0) && t >= 2 * bt && t <= 9 * bt;
      if (noisy && !sample_tick) begin
        lvl = 1'($urandom_range(1));
      end
      send_tick(lvl);
    end
    while (sb.is_busy()) begin
      if (end_edge && sb.last_busy_tick()) begin
        send_tick(1'b0);
      end else begin
        send_tick(noisy ? 1'($urandom_range(1)) : 1'b1);
      end
    end
    if (end_edge) begin
      send_tick(1'b0);
    end
  endtask

  task automatic settle();
    while (sb.is_busy()) send_tick(1'b1);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] bit_val, input logic [7:0] start_val);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_BIT_TICKS;
    cfg_data  <= bit_val;
    @(negedge clk);
    sb.write_reg(CFG_BIT_TICKS, bit_val);
    cfg_index <= CFG_START_TICKS;
    cfg_data  <= start_val;
    @(negedge clk);
    sb.write_reg(CFG_START_TICKS, start_val);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_traffic(input int unsigned n_ticks);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  b;
    stop_at = sb.ticks + n_ticks;
    while (sb.ticks < stop_at) begin
      pick = $urandom_range(99);
      if ($urandom_range(99) < 60) begin
        b = 8'("0" + $urandom_range(9));
      end else begin
        b = 8'($urandom_range(255));
      end
      if (pick < 70) begin
        send_frame(b, 1'b0, 1'b0);
      end else if (pick < 82) begin
        send_frame(b, 1'b1, 1'($urandom_range(1)));
      end else if (pick < 90) begin
        send_frame(b, 1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 16)) send_tick(1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int d;
    sb = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    rx_level  = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_BIT_TICKS;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset timing, every command, bytes around the digits, glitches
    send_frame("4", 1'b0, 1'b0);
    configure(8'd1, 8'd1);
    for (d = 0; d < 10; d++) begin
      send_frame(8'("0" + d), 1'b0, 1'b0);
    end
    send_frame(8'h00, 1'b0, 1'b0);
    send_frame(8'hFF, 1'b0, 1'b0);
    send_frame("/", 1'b0, 1'b0);
    send_frame(":", 1'b0, 1'b0);
    send_frame("6", 1'b1, 1'b0);
    send_frame("2", 1'b0, 1'b1);
    configure(8'd0, 8'd1);
    send_frame("1", 1'b0, 1'b0);
    send_frame("A", 1'b0, 1'b0);
    configure(8'd1, 8'd255);
    send_frame("3", 1'b0, 1'b0);

    // random frames under different timings and flow control
    configure(8'd1, 8'd1);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_out = 1'b1;
    random_traffic(140);
    configure(8'd2, 8'd3);
    src_idle_pct = 80;
    sink_stall_pct = 0;
    random_traffic(140);
    configure(8'd3, 8'd1);
    src_idle_pct = 0;
    sink_stall_pct = 80;
    random_traffic(140);
    configure(8'd1, 8'd2);
    src_idle_pct = 24;
    sink_stall_pct = 24;
    random_traffic(140);
    configure(8'd0, 8'd4);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    random_traffic(140);

    settle();
    repeat (10) @(negedge clk);
    $display("run covered %0d ticks: %0d commands decoded, %0d bytes rejected,",
             sb.ticks, sb.commands, sb.rejects);
    $display("bit times of 0 to 12 ticks, start times up to 255, stalls on both sides");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[uart_command_channel_selector] OK");
    end else begin
      $display("[uart_command_channel_selector] ERROR");
    end
    $finish;
  end

endmodule
